// ===== design/btpc_pkg.sv =====
// Shared types, constants and helper functions for the barometer compensation block.
// Used by every module of the block except btpc_mul64; depends on nothing else.
`default_nettype none

package btpc_pkg;

    localparam int NSTAGE = 15;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    localparam logic [1:0] REG_TEMP    = 2'd0;
    localparam logic [1:0] REG_PRESS_A = 2'd1;
    localparam logic [1:0] REG_PRESS_B = 2'd2;
    localparam logic [1:0] REG_PRESS_C = 2'd3;

    typedef struct packed {
        logic [23:0] raw_temperature;
        logic [23:0] raw_pressure;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] temperature_centideg;
        logic [31:0]        pressure_centipascal;
    } out_item_t;

    typedef struct packed {
        logic [39:0] temp_coeffs;
        logic [47:0] press_coeffs_a;
        logic [47:0] press_coeffs_b;
        logic [31:0] press_coeffs_c;
    } cfg_t;

    typedef struct packed {
        logic [NSTAGE:1] en;
        logic [NSTAGE:1] valid;
    } pipe_ctrl_t;

    // Signed division by a power of two, rounding toward zero.
    function automatic logic [63:0] sdiv(input logic [63:0] x, input logic [5:0] sh);
        logic [63:0] bias;
        bias = x[63] ? ((64'd1 << sh) - 64'd1) : 64'd0;
        return $unsigned($signed(x + bias) >>> sh);
    endfunction

endpackage

`default_nettype wire

// ===== design/btpc_mul64.sv =====
// Two-stage multiplier returning the low 64 bits of a 64 by 64 bit product.
// Built from 32 by 32 bit partial products; no package dependencies.
`default_nettype none

module btpc_mul64 (
    input  logic        clk,
    input  logic        en_lo,
    input  logic        en_hi,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [63:0] p_reg;
    logic [63:0] ll_next;
    logic [31:0] lh_next;
    logic [31:0] hl_next;

    assign ll_next = 64'(a[31:0]) * 64'(b[31:0]);
    assign lh_next = a[31:0] * b[63:32];
    assign hl_next = a[63:32] * b[31:0];

    always_ff @(posedge clk)
    begin
        if (en_lo)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
        end
        if (en_hi)
        begin
            p_reg <= ll_reg + {lh_reg + hl_reg, 32'd0};
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== design/btpc_regs.sv =====
// APB-style register file holding the four calibration coefficient registers.
// Depends on btpc_pkg for the register layout and address constants.
`default_nettype none

module btpc_regs
    import btpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TEMP:    cfg_reg.temp_coeffs    <= pwdata[39:0];
                REG_PRESS_A: cfg_reg.press_coeffs_a <= pwdata[47:0];
                REG_PRESS_B: cfg_reg.press_coeffs_b <= pwdata[47:0];
                REG_PRESS_C: cfg_reg.press_coeffs_c <= pwdata[31:0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TEMP:    prdata = 64'(cfg_reg.temp_coeffs);
            REG_PRESS_A: prdata = 64'(cfg_reg.press_coeffs_a);
            REG_PRESS_B: prdata = 64'(cfg_reg.press_coeffs_b);
            REG_PRESS_C: prdata = 64'(cfg_reg.press_coeffs_c);
            default:     prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/btpc_pipe_ctrl.sv =====
// Valid bits and per-stage load enables of the compensation pipeline.
// Depends on btpc_pkg for the stage count and the control struct.
`default_nettype none

module btpc_pipe_ctrl
    import btpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_stall,
    output logic       in_stall,
    output pipe_ctrl_t ctrl
);

    logic [NSTAGE:1] valid_reg;
    logic [NSTAGE:1] en;

    always_comb
    begin
        en[NSTAGE] = !valid_reg[NSTAGE] || !out_stall;
        for (int k = NSTAGE - 1; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                valid_reg[1] <= in_valid;
            end
            for (int k = 2; k <= NSTAGE; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign in_stall   = !en[1];
    assign ctrl.en    = en;
    assign ctrl.valid = valid_reg;

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[1])
        else $error("Accepted transaction did not enter the first stage.");

    a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NSTAGE-1] && !out_stall) |=> valid_reg[NSTAGE])
        else $error("Transaction lost before the output stage.");

    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("Input stalled although the output is free.");
`endif

endmodule

`default_nettype wire

// ===== design/baro_temp_pressure_compensation.sv =====
// Barometer temperature and pressure compensation, 64-bit integer polynomials.
// The result of each accepted input transaction becomes valid at the output of the last pipeline stage.
// Throughput: one transaction per cycle; stages hold only while the output stalls.
// Reset clears the pipeline valid bits and all coefficient registers to zero.
// Depends on btpc_pkg, btpc_regs, btpc_pipe_ctrl and btpc_mul64.
`default_nettype none

module baro_temp_pressure_compensation
    import btpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t            cfg;
    pipe_ctrl_t      ctrl;
    logic [NSTAGE:1] en;

    btpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    btpc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .ctrl      (ctrl)
    );

    assign en = ctrl.en;

    logic [15:0]        t1;
    logic [15:0]        t2;
    logic signed [7:0]  t3;
    logic signed [16:0] p1m;
    logic signed [16:0] p2m;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic [15:0]        p5;
    logic [15:0]        p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;

    assign t1  = cfg.temp_coeffs[15:0];
    assign t2  = cfg.temp_coeffs[31:16];
    assign t3  = $signed(cfg.temp_coeffs[39:32]);
    assign p1m = 17'($signed(cfg.press_coeffs_a[15:0])) - 17'sd16384;
    assign p2m = 17'($signed(cfg.press_coeffs_a[31:16])) - 17'sd16384;
    assign p3  = $signed(cfg.press_coeffs_a[39:32]);
    assign p4  = $signed(cfg.press_coeffs_a[47:40]);
    assign p5  = cfg.press_coeffs_b[15:0];
    assign p6  = cfg.press_coeffs_b[31:16];
    assign p7  = $signed(cfg.press_coeffs_b[39:32]);
    assign p8  = $signed(cfg.press_coeffs_b[47:40]);
    assign p9  = $signed(cfg.press_coeffs_c[15:0]);
    assign p10 = $signed(cfg.press_coeffs_c[23:16]);
    assign p11 = $signed(cfg.press_coeffs_c[31:24]);

    logic signed [25:0] d_reg;
    logic signed [42:0] m1_reg;
    logic signed [51:0] m2_reg;
    logic [63:0]        a_reg;
    logic [63:0]        tc_reg;
    logic [63:0]        s3_reg;
    logic [47:0]        rp2_reg;
    logic [63:0]        s6pre_reg;
    logic [63:0]        q3_reg;
    logic [63:0]        pq8_reg;
    logic [63:0]        pq4_reg;
    logic [63:0]        sens_reg;
    logic [63:0]        sum_reg;
    out_item_t          out_data_reg;

    logic [23:0] rp_reg     [1:11];
    logic [63:0] tf_reg     [4:6];
    logic [15:0] tout_reg   [6:14];
    logic [63:0] pt6_reg    [5:10];
    logic [63:0] pt2_reg    [5:10];
    logic [63:0] pq7_reg    [7:10];
    logic [63:0] pq3_reg    [7:10];
    logic [63:0] s7_reg     [9:13];
    logic [63:0] s5_reg     [10:13];
    logic [63:0] offset_reg [11:13];

    logic signed [25:0] d_next;
    logic signed [42:0] m1_next;
    logic signed [51:0] m2_next;
    logic signed [59:0] m2t3;
    logic [63:0]        a_next;
    logic [63:0]        tf25;
    logic [63:0]        s3_next;
    logic [63:0]        pt6_next;
    logic [63:0]        pt2_next;
    logic [47:0]        rp2_next;
    logic [15:0]        tout_next;
    logic [63:0]        s6pre_next;
    logic [63:0]        pq7_next;
    logic [63:0]        pq3_next;
    logic [63:0]        pq8_next;
    logic [63:0]        pq4_next;
    logic [63:0]        offset_next;
    logic [63:0]        sens_next;
    logic [63:0]        sum_next;
    logic [27:0]        hi25;
    logic [44:0]        lo25;
    logic [31:0]        pout_next;

    logic [63:0] q1;
    logic [63:0] q2tf;
    logic [63:0] s4pre;
    logic [63:0] s5pre;
    logic [63:0] s7pre;
    logic [63:0] s1;

    btpc_mul64 u_mul_q1 (
        .clk (clk), .en_lo (en[5]), .en_hi (en[6]),
        .a (tf_reg[4]), .b (tf_reg[4]), .p (q1)
    );

    btpc_mul64 u_mul_s4 (
        .clk (clk), .en_lo (en[6]), .en_hi (en[7]),
        .a (s3_reg), .b (64'(rp_reg[5])), .p (s4pre)
    );

    btpc_mul64 u_mul_q3 (
        .clk (clk), .en_lo (en[7]), .en_hi (en[8]),
        .a (sdiv(q1, 6'd6)), .b (tf_reg[6]), .p (q2tf)
    );

    btpc_mul64 u_mul_s7 (
        .clk (clk), .en_lo (en[7]), .en_hi (en[8]),
        .a (sdiv(s6pre_reg, 6'd16)), .b (64'(rp_reg[6])), .p (s7pre)
    );

    btpc_mul64 u_mul_s5 (
        .clk (clk), .en_lo (en[8]), .en_hi (en[9]),
        .a (sdiv(s4pre, 6'd13)), .b (64'(rp_reg[7])), .p (s5pre)
    );

    btpc_mul64 u_mul_s1 (
        .clk (clk), .en_lo (en[12]), .en_hi (en[13]),
        .a (sdiv(sens_reg, 6'd24)), .b (64'(rp_reg[11])), .p (s1)
    );

    always_comb
    begin
        d_next   = $signed({2'b00, in_data.raw_temperature}) - $signed({2'b00, t1, 8'h00});
        m1_next  = $signed({1'b0, t2}) * d_reg;
        m2_next  = d_reg * d_reg;
        m2t3     = m2_reg * t3;
        a_next   = $unsigned(($signed(64'(m1_reg)) <<< 18) + $signed(64'(m2t3)));
        tf25     = (tf_reg[4] << 4) + (tf_reg[4] << 3) + tf_reg[4];
        s3_next  = $unsigned($signed(tf_reg[4]) * p10) + ($unsigned(64'(p9)) << 16);
        pt6_next = $unsigned($signed(tf_reg[4]) * $signed({1'b0, p6}));
        pt2_next = $unsigned($signed(tf_reg[4]) * p2m);
        rp2_next = rp_reg[4] * rp_reg[4];

        if ($signed(tc_reg) > 64'sd32767)
        begin
            tout_next = 16'h7FFF;
        end
        else if ($signed(tc_reg) < -64'sd32768)
        begin
            tout_next = 16'h8000;
        end
        else
        begin
            tout_next = tc_reg[15:0];
        end

        s6pre_next  = $unsigned(64'(p11) * 64'($signed({1'b0, rp2_reg})));
        pq7_next    = $unsigned($signed(q1) * p7);
        pq3_next    = $unsigned($signed(q1) * p3);
        pq8_next    = $unsigned($signed(q3_reg) * p8);
        pq4_next    = $unsigned($signed(q3_reg) * p4);
        offset_next = {1'b0, p5, 47'd0} + sdiv(pq8_reg, 6'd5)
                    + (pq7_reg[10] << 4) + (pt6_reg[10] << 22);
        sens_next   = ($unsigned(64'(p1m)) << 46) + sdiv(pq4_reg, 6'd5)
                    + (pq3_reg[10] << 2) + (pt2_reg[10] << 21);
        sum_next    = sdiv(offset_reg[13], 6'd2) + s1 + s5_reg[13] + s7_reg[13];

        hi25 = 28'(sum_reg[62:40]) * 28'd25;
        lo25 = 45'(sum_reg[39:0]) * 45'd25;
        if (sum_reg[63])
        begin
            pout_next = '0;
        end
        else
        begin
            pout_next = 32'(hi25) + 32'(lo25[44:40]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            d_reg     <= d_next;
            rp_reg[1] <= in_data.raw_pressure;
        end
        for (int k = 2; k <= 11; k++)
        begin
            if (en[k])
            begin
                rp_reg[k] <= rp_reg[k-1];
            end
        end
        if (en[2])
        begin
            m1_reg <= m1_next;
            m2_reg <= m2_next;
        end
        if (en[3])
        begin
            a_reg <= a_next;
        end
        if (en[4])
        begin
            tf_reg[4] <= sdiv(a_reg, 6'd32);
        end
        if (en[5])
        begin
            tf_reg[5]  <= tf_reg[4];
            tc_reg     <= sdiv(tf25, 6'd14);
            s3_reg     <= s3_next;
            pt6_reg[5] <= pt6_next;
            pt2_reg[5] <= pt2_next;
            rp2_reg    <= rp2_next;
        end
        if (en[6])
        begin
            tf_reg[6]   <= tf_reg[5];
            tout_reg[6] <= tout_next;
            s6pre_reg   <= s6pre_next;
        end
        for (int k = 7; k <= 14; k++)
        begin
            if (en[k])
            begin
                tout_reg[k] <= tout_reg[k-1];
            end
        end
        for (int k = 6; k <= 10; k++)
        begin
            if (en[k])
            begin
                pt6_reg[k] <= pt6_reg[k-1];
                pt2_reg[k] <= pt2_reg[k-1];
            end
        end
        if (en[7])
        begin
            pq7_reg[7] <= pq7_next;
            pq3_reg[7] <= pq3_next;
        end
        for (int k = 8; k <= 10; k++)
        begin
            if (en[k])
            begin
                pq7_reg[k] <= pq7_reg[k-1];
                pq3_reg[k] <= pq3_reg[k-1];
            end
        end
        if (en[9])
        begin
            q3_reg    <= sdiv(q2tf, 6'd8);
            s7_reg[9] <= sdiv(s7pre, 6'd7);
        end
        if (en[10])
        begin
            pq8_reg    <= pq8_next;
            pq4_reg    <= pq4_next;
            s5_reg[10] <= sdiv(s5pre, 6'd9);
        end
        for (int k = 10; k <= 13; k++)
        begin
            if (en[k])
            begin
                s7_reg[k] <= s7_reg[k-1];
            end
        end
        for (int k = 11; k <= 13; k++)
        begin
            if (en[k])
            begin
                s5_reg[k] <= s5_reg[k-1];
            end
        end
        if (en[11])
        begin
            offset_reg[11] <= offset_next;
            sens_reg       <= sens_next;
        end
        for (int k = 12; k <= 13; k++)
        begin
            if (en[k])
            begin
                offset_reg[k] <= offset_reg[k-1];
            end
        end
        if (en[14])
        begin
            sum_reg <= sum_next;
        end
        if (en[15])
        begin
            out_data_reg.temperature_centideg <= $signed(tout_reg[14]);
            out_data_reg.pressure_centipascal <= pout_next;
        end
    end

    assign out_valid = ctrl.valid[NSTAGE];
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== tb/sv/baro_temp_pressure_compensation_tb.sv =====
// Testbench for the barometer temperature and pressure compensation block.
// Drives random and directed transactions and register writes, predicting each result.
// Depends on btpc_pkg and baro_temp_pressure_compensation.
`timescale 1ns / 100ps

module baro_temp_pressure_compensation_tb;
    import btpc_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    in_item_t          in_data;
    logic              out_valid;
    logic              out_stall;
    out_item_t         out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic [39:0] tc_reg;
    logic [47:0] pa_reg;
    logic [47:0] pb_reg;
    logic [31:0] pc_reg;

    in_item_t  pending_samples[$];
    out_item_t expected_readings[$];
    int        errors;
    int        send_gap;
    int        stall_len;
    int        sent_count;

    baro_temp_pressure_compensation DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] x,
                                                       input int sh);
        logic [63:0] mag;
        if (x < 0)
        begin
            mag = -x;
            return -$signed(mag >> sh);
        end
        return x >>> sh;
    endfunction

    function automatic out_item_t compensate(input in_item_t s);
        logic signed [63:0] rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        logic signed [63:0] d, a, tf, tcen, q1, q2, q3, offs, sens, s1, s3, s4, s5, s6, s7;
        logic signed [63:0] total;
        logic [63:0] pr;
        out_item_t r;
        rt = {40'd0, s.raw_temperature};
        rp = {40'd0, s.raw_pressure};
        t1 = {48'd0, tc_reg[15:0]};
        t2 = {48'd0, tc_reg[31:16]};
        t3 = {{56{tc_reg[39]}}, tc_reg[39:32]};
        p1 = {{48{pa_reg[15]}}, pa_reg[15:0]};
        p2 = {{48{pa_reg[31]}}, pa_reg[31:16]};
        p3 = {{56{pa_reg[39]}}, pa_reg[39:32]};
        p4 = {{56{pa_reg[47]}}, pa_reg[47:40]};
        p5 = {48'd0, pb_reg[15:0]};
        p6 = {48'd0, pb_reg[31:16]};
        p7 = {{56{pb_reg[39]}}, pb_reg[39:32]};
        p8 = {{56{pb_reg[47]}}, pb_reg[47:40]};
        p9 = {{48{pc_reg[15]}}, pc_reg[15:0]};
        p10 = {{56{pc_reg[23]}}, pc_reg[23:16]};
        p11 = {{56{pc_reg[31]}}, pc_reg[31:24]};
        d = rt - 256 * t1;
        a = (t2 * d) * 262144 + (d * d) * t3;
        tf = trunc_shift(a, 32);
        tcen = trunc_shift(tf * 25, 14);
        if (tcen < -32768)
            r.temperature_centideg = 16'h8000;
        else if (tcen > 32767)
            r.temperature_centideg = 16'h7FFF;
        else
            r.temperature_centideg = tcen[15:0];
        q1 = tf * tf;
        q2 = trunc_shift(q1, 6);
        q3 = trunc_shift(q2 * tf, 8);
        offs = p5 * 64'sd140737488355328 + trunc_shift(p8 * q3, 5) + p7 * q1 * 16
             + p6 * tf * 4194304;
        sens = (p1 - 16384) * 64'sd70368744177664 + trunc_shift(p4 * q3, 5) + p3 * q1 * 4
             + (p2 - 16384) * tf * 2097152;
        s1 = trunc_shift(sens, 24) * rp;
        s3 = p10 * tf + 65536 * p9;
        s4 = trunc_shift(s3 * rp, 13);
        s5 = trunc_shift(s4 * rp, 9);
        s6 = trunc_shift(p11 * (rp * rp), 16);
        s7 = trunc_shift(s6 * rp, 7);
        total = trunc_shift(offs, 2) + s1 + s5 + s7;
        if (total < 0)
            pr = 64'd0;
        else
            pr = (total >> 40) * 25 + ((({24'd0, total[39:0]}) * 25) >> 40);
        r.pressure_centipascal = (pr > 64'hFFFFFFFF) ? 32'hFFFFFFFF : pr[31:0];
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 3;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TEMP: tc_reg = value[39:0];
            REG_PRESS_A: pa_reg = value[47:0];
            REG_PRESS_B: pb_reg = value[47:0];
            default: pc_reg = value[31:0];
        endcase
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic in_item_t rand_sample(input int mode);
        in_item_t s;
        s.raw_temperature = 24'($urandom);
        s.raw_pressure = 24'($urandom);
        if (mode == 1)
        begin
            s.raw_temperature = 24'($urandom_range(6000000, 10000000));
            s.raw_pressure = 24'($urandom_range(4000000, 10000000));
        end
        return s;
    endfunction

    // Send a batch and wait until every result is back before returning.
    task automatic run_batch(input in_item_t items[$]);
        foreach (items[i])
            pending_samples.push_back(items[i]);
        wait (pending_samples.size() == 0 && expected_readings.size() == 0 && !in_valid);
        repeat (20) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            expected_readings.push_back(compensate(in_data));
            sent_count <= sent_count + 1;
        end
        if ((in_valid && !in_stall) || !in_valid)
        begin
            if (send_gap > 0 || pending_samples.size() == 0 || !rst_n)
            begin
                in_valid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                in_valid <= 1'b1;
                in_data <= pending_samples.pop_front();
                send_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall && rst_n)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                out_item_t e;
                e = expected_readings.pop_front();
                if (out_data.temperature_centideg !== e.temperature_centideg)
                begin
                    $error("temperature_centideg expected %0d actual %0d",
                           e.temperature_centideg, out_data.temperature_centideg);
                    errors++;
                end
                if (out_data.pressure_centipascal !== e.pressure_centipascal)
                begin
                    $error("pressure_centipascal expected %0d actual %0d",
                           e.pressure_centipascal, out_data.pressure_centipascal);
                    errors++;
                end
            end
        end
        if (stall_len > 0)
        begin
            out_stall <= 1'b1;
            stall_len <= stall_len - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_stall <= 1'b1;
            stall_len <= pick_gap();
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        #400000;
        $display("baro_temp_pressure_compensation_tb failed");
        $finish;
    end

    initial
    begin
        in_item_t batch[$];
        in_item_t s;
        logic [63:0] typical_t;
        logic [63:0] typical_a;
        logic [63:0] typical_b;
        logic [63:0] typical_c;
        errors = 0;
        send_gap = 0;
        stall_len = 0;
        sent_count = 0;
        tc_reg = '0;
        pa_reg = '0;
        pb_reg = '0;
        pc_reg = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        typical_t = {8'h03, 16'd18000, 16'd27500};
        typical_a = {8'h03, 8'hF8, 16'hFFE0, 16'hFFF0};
        typical_b = {8'hFC, 8'h0C, 16'd15000, 16'd24000};
        typical_c = {8'h02, 8'h0A, 16'h0015};

        // Reset coefficients, then the extremes of the raw fields.
        batch = {};
        s.raw_temperature = 24'h0; s.raw_pressure = 24'h0; batch.push_back(s);
        s.raw_temperature = 24'hFFFFFF; s.raw_pressure = 24'hFFFFFF; batch.push_back(s);
        s.raw_temperature = 24'h0; s.raw_pressure = 24'hFFFFFF; batch.push_back(s);
        s.raw_temperature = 24'hFFFFFF; s.raw_pressure = 24'h0; batch.push_back(s);
        run_batch(batch);

        write_reg(REG_TEMP, typical_t);
        write_reg(REG_PRESS_A, typical_a);
        write_reg(REG_PRESS_B, typical_b);
        write_reg(REG_PRESS_C, typical_c);
        batch = {};
        s.raw_temperature = 24'd8388608; s.raw_pressure = 24'd6000000; batch.push_back(s);
        s.raw_temperature = 24'h0; s.raw_pressure = 24'h0; batch.push_back(s);
        s.raw_temperature = 24'hFFFFFF; s.raw_pressure = 24'hFFFFFF; batch.push_back(s);
        s.raw_temperature = 24'h555555; s.raw_pressure = 24'hAAAAAA; batch.push_back(s);
        s.raw_temperature = 24'hAAAAAA; s.raw_pressure = 24'h555555; batch.push_back(s);
        run_batch(batch);

        // All coefficient bits set: signed fields at -1, unsigned at their top.
        write_reg(REG_TEMP, 64'hFF_FFFF_FFFF);
        write_reg(REG_PRESS_A, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_PRESS_B, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_PRESS_C, 64'hFFFF_FFFF);
        batch = {};
        for (int i = 0; i < 6; i++)
            batch.push_back(rand_sample(0));
        run_batch(batch);

        // Signed fields at their most positive and most negative values.
        write_reg(REG_TEMP, {8'h7F, 16'hFFFF, 16'h0000});
        write_reg(REG_PRESS_A, {8'h80, 8'h7F, 16'h8000, 16'h7FFF});
        write_reg(REG_PRESS_B, {8'h7F, 8'h80, 16'hFFFF, 16'hFFFF});
        write_reg(REG_PRESS_C, {8'h80, 8'h7F, 16'h8000});
        batch = {};
        for (int i = 0; i < 6; i++)
            batch.push_back(rand_sample(0));
        run_batch(batch);

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase % 2 == 0)
            begin
                write_reg(REG_TEMP, typical_t ^ {40'd0, 8'($urandom), 16'($urandom_range(0, 2047))});
                write_reg(REG_PRESS_A, typical_a ^ {56'd0, 8'($urandom)});
                write_reg(REG_PRESS_B, typical_b ^ {48'd0, 16'($urandom_range(0, 4095))});
                write_reg(REG_PRESS_C, typical_c ^ {56'd0, 8'($urandom)});
            end
            else
            begin
                write_reg(REG_TEMP, {$urandom, $urandom});
                write_reg(REG_PRESS_A, {$urandom, $urandom});
                write_reg(REG_PRESS_B, {$urandom, $urandom});
                write_reg(REG_PRESS_C, {32'd0, $urandom});
            end
            batch = {};
            for (int i = 0; i < 120; i++)
                batch.push_back(rand_sample((phase % 2 == 0 && i % 4 != 0) ? 1 : 0));
            run_batch(batch);
        end

        if (errors == 0)
            $display("baro_temp_pressure_compensation_tb passed");
        else
            $display("baro_temp_pressure_compensation_tb failed");
        $finish;
    end

endmodule
